>>> hdl/indexed_min_heap_defines.svh
// ----------------------------------------------------------------------------
// Indexed min-heap assertion macros
// Shared assertion forms used by the heap RTL.
// ----------------------------------------------------------------------------
`ifndef INDEXED_MIN_HEAP_DEFINES_SVH
`define INDEXED_MIN_HEAP_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define IMH_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define IMH_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/imh_pkg.sv
// ----------------------------------------------------------------------------
// Indexed min-heap package
// Sizes, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none
package imh_pkg;
    localparam int Capacity  = 64;
    localparam int KeySpace  = 256;
    localparam int PrioWidth = 32;
    localparam int SlotW     = $clog2(Capacity);
    localparam int CountW    = $clog2(Capacity + 1);
    localparam int KeyW      = $clog2(KeySpace);
    localparam int EntryW    = KeyW + PrioWidth;

    typedef logic [2:0] op_t;
    localparam op_t OP_INSERT = 3'd0;
    localparam op_t OP_POPMIN = 3'd1;
    localparam op_t OP_CHANGE = 3'd2;
    localparam op_t OP_DELETE = 3'd3;
    localparam op_t OP_QUERY  = 3'd4;
    localparam op_t OP_PEEK   = 3'd5;

    typedef logic [2:0] status_t;
    localparam status_t ST_OK     = 3'd0;
    localparam status_t ST_FULL   = 3'd1;
    localparam status_t ST_ABSENT = 3'd2;
    localparam status_t ST_DUP    = 3'd3;
    localparam status_t ST_EMPTY  = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE, S_LOOK, S_RDLAST, S_DECIDE,
        S_UPRD, S_UPCMP, S_DNRD, S_DNCMP, S_DNCMP2,
        S_ROOT, S_QRY, S_OUT
    } state_t;
endpackage
`default_nettype wire

>>> hdl/indexed_min_heap.sv
// Query, peek and refused items walk no level; insert walks up, change and
// delete walk up or down, and pop walks down.
// One item at a time: the next is taken in the idle cycle after the result is
// loaded; a result still waiting holds the walk before its output load.
// After reset a sweep over all 256 keys marks every key absent; no item is taken then.
// ----------------------------------------------------------------------------
// Indexed min-heap
// Binary min-heap of (key, priority) with a key-to-slot table, one op per item.
// ----------------------------------------------------------------------------
`default_nettype none
`include "indexed_min_heap_defines.svh"
module indexed_min_heap (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // op[2:0], key[10:3], priority_req[42:11], zero fill
    input  wire logic [47:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // min_key[7:0], min_priority[39:8], is_empty[40], key_present[41],
    // key_priority[73:42], count[80:74], status[83:81], zero fill
    output logic [87:0]      m_tdata
);
    localparam int SW = imh_pkg::SlotW;
    localparam int CW = imh_pkg::CountW;
    localparam int KW = imh_pkg::KeyW;
    localparam int PW = imh_pkg::PrioWidth;
    localparam int EW = imh_pkg::EntryW;
    localparam logic [CW-1:0] CapCnt = CW'(imh_pkg::Capacity);

    imh_pkg::state_t state_reg, state_next;

    // Captured item.
    imh_pkg::op_t   op_reg, op_next;
    logic [KW-1:0]  key_reg, key_next;
    logic [PW-1:0]  pri_reg, pri_next;
    // Working registers.
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [SW-1:0]  idx_reg, idx_next;       // current node of the walk
    logic [SW-1:0]  oth_reg, oth_next;       // parent or chosen child
    logic [EW-1:0]  node_reg, node_next;     // entry moving through the heap
    logic [PW-1:0]  gone_reg, gone_next;     // priority of the replaced entry
    logic [EW-1:0]  lc_reg, lc_next;         // left child held during down step
    imh_pkg::status_t st_reg, st_next;
    logic [87:0]    out_reg, out_next;
    logic           ov_reg, ov_next;
    // Reset sweep over the position table.
    logic           clr_reg, clr_next;
    logic [KW:0]    clr_cnt_reg, clr_cnt_next;

    // Heap memory.
    logic           h_we;
    logic [SW-1:0]  h_wa, h_ra;
    logic [EW-1:0]  h_wd, h_rd;
    // Position table: valid bit above the slot.
    logic           p_we;
    logic [KW-1:0]  p_wa, p_ra;
    logic [SW:0]    p_wd, p_rd;

    imh_ram #(.Width(EW), .Depth(imh_pkg::Capacity)) u_heap (
        .aclk(aclk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd)
    );
    imh_ram #(.Width(SW + 1), .Depth(imh_pkg::KeySpace)) u_pos (
        .aclk(aclk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd)
    );

    logic signed [PW-1:0] rd_pri, node_pri, lc_pri;
    assign rd_pri   = h_rd[EW-1:KW];
    assign node_pri = node_reg[EW-1:KW];
    assign lc_pri   = lc_reg[EW-1:KW];

    // Shared comparator: a >= b, signed.
    logic signed [PW-1:0] cmp_a, cmp_b;
    logic                 cmp_ge;
    assign cmp_ge = (cmp_a >= cmp_b);

    logic [CW:0] lchild;   // 2*idx+1, may exceed count
    assign lchild = {1'b0, idx_reg, 1'b1};

    // Handshake terms for the checks below.
    logic s_acc, m_wait;
    assign s_acc  = s_tvalid && s_tready;
    assign m_wait = m_tvalid && !m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= imh_pkg::S_IDLE;
            cnt_reg     <= '0;
            ov_reg      <= 1'b0;
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            ov_reg      <= ov_next;
            clr_reg     <= clr_next;
            clr_cnt_reg <= clr_cnt_next;
        end
        op_reg   <= op_next;
        key_reg  <= key_next;
        pri_reg  <= pri_next;
        idx_reg  <= idx_next;
        oth_reg  <= oth_next;
        node_reg <= node_next;
        gone_reg <= gone_next;
        lc_reg   <= lc_next;
        st_reg   <= st_next;
        out_reg  <= out_next;
    end

    assign s_tready = (state_reg == imh_pkg::S_IDLE) && !clr_reg;
    assign m_tvalid = ov_reg;
    assign m_tdata  = out_reg;

    always_comb begin
        state_next = state_reg;
        op_next = op_reg;  key_next = key_reg;  pri_next = pri_reg;
        cnt_next = cnt_reg; idx_next = idx_reg; oth_next = oth_reg;
        node_next = node_reg; gone_next = gone_reg; lc_next = lc_reg;
        st_next = st_reg; out_next = out_reg; ov_next = ov_reg;
        clr_next = clr_reg; clr_cnt_next = clr_cnt_reg;
        h_we = 1'b0; h_wa = '0; h_wd = node_reg; h_ra = '0;
        p_we = 1'b0; p_wa = key_reg; p_wd = '0; p_ra = key_reg;
        cmp_a = node_pri; cmp_b = rd_pri;

        if (ov_reg && m_tready) begin
            ov_next = 1'b0;
        end

        // Sweep: mark every key absent.
        if (clr_reg) begin
            p_we = 1'b1;
            p_wa = clr_cnt_reg[KW-1:0];
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == (KW+1)'(imh_pkg::KeySpace - 1)) begin
                clr_next = 1'b0;
            end
        end

        case (state_reg)
            imh_pkg::S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    op_next   = s_tdata[2:0];
                    key_next  = s_tdata[3 +: KW];
                    pri_next  = s_tdata[11 +: PW];
                    st_next   = imh_pkg::ST_OK;
                    state_next = imh_pkg::S_LOOK;
                end
            end
            imh_pkg::S_LOOK: begin
                // Position read issued; last entry read for pop and delete.
                p_ra = key_reg;
                h_ra = SW'(cnt_reg - 1'b1);
                state_next = imh_pkg::S_RDLAST;
            end
            imh_pkg::S_RDLAST: begin
                // p_rd valid; h_rd holds the last entry.
                node_next = h_rd;
                idx_next  = p_rd[SW-1:0];
                h_ra = p_rd[SW-1:0];
                state_next = imh_pkg::S_DECIDE;
                case (op_reg)
                    imh_pkg::OP_INSERT: begin
                        if (p_rd[SW]) begin
                            st_next = imh_pkg::ST_DUP;
                            state_next = imh_pkg::S_ROOT;
                        end else if (cnt_reg == CW'(imh_pkg::Capacity)) begin
                            st_next = imh_pkg::ST_FULL;
                            state_next = imh_pkg::S_ROOT;
                        end else begin
                            node_next = {pri_reg, key_reg};
                            idx_next  = SW'(cnt_reg);
                            cnt_next  = cnt_reg + 1'b1;
                            state_next = imh_pkg::S_UPRD;
                        end
                    end
                    imh_pkg::OP_POPMIN, imh_pkg::OP_PEEK: begin
                        if (cnt_reg == '0) begin
                            st_next = imh_pkg::ST_EMPTY;
                            state_next = imh_pkg::S_ROOT;
                        end else if (op_reg == imh_pkg::OP_PEEK) begin
                            state_next = imh_pkg::S_ROOT;
                        end else begin
                            h_ra = '0;
                            idx_next = '0;
                        end
                    end
                    imh_pkg::OP_CHANGE, imh_pkg::OP_DELETE, imh_pkg::OP_QUERY: begin
                        if (!p_rd[SW]) begin
                            st_next = imh_pkg::ST_ABSENT;
                            state_next = imh_pkg::S_ROOT;
                        end else if (op_reg == imh_pkg::OP_QUERY) begin
                            state_next = imh_pkg::S_ROOT;
                        end
                    end
                    default: state_next = imh_pkg::S_ROOT;
                endcase
            end
            imh_pkg::S_DECIDE: begin
                // h_rd holds the entry at idx (root for pop).
                gone_next = rd_pri;
                case (op_reg)
                    imh_pkg::OP_POPMIN: begin
                        p_we = 1'b1; p_wa = h_rd[KW-1:0]; p_wd = '0;
                        cnt_next = cnt_reg - 1'b1;
                        state_next = (cnt_reg == CW'(1)) ? imh_pkg::S_ROOT
                                                         : imh_pkg::S_DNRD;
                    end
                    imh_pkg::OP_DELETE: begin
                        p_we = 1'b1; p_wa = h_rd[KW-1:0]; p_wd = '0;
                        cnt_next = cnt_reg - 1'b1;
                        if (idx_reg == SW'(cnt_reg - 1'b1)) begin
                            state_next = imh_pkg::S_ROOT;
                        end else begin
                            cmp_a = node_pri; cmp_b = rd_pri;
                            // moved < gone -> up, else down
                            state_next = cmp_ge ? imh_pkg::S_DNRD : imh_pkg::S_UPRD;
                        end
                    end
                    default: begin
                        // change
                        node_next = {pri_reg, key_reg};
                        cmp_a = pri_reg; cmp_b = rd_pri;
                        if ($signed(pri_reg) == rd_pri) begin
                            node_next = {pri_reg, key_reg};
                            state_next = imh_pkg::S_UPRD;
                        end else begin
                            state_next = cmp_ge ? imh_pkg::S_DNRD : imh_pkg::S_UPRD;
                        end
                    end
                endcase
            end
            imh_pkg::S_UPRD: begin
                // Place node at idx; read parent.
                h_we = 1'b1; h_wa = idx_reg; h_wd = node_reg;
                p_we = 1'b1; p_wa = node_reg[KW-1:0]; p_wd = {1'b1, idx_reg};
                oth_next = SW'((idx_reg - 1'b1) >> 1);
                h_ra = SW'((idx_reg - 1'b1) >> 1);
                if (idx_reg == '0 || (op_reg == imh_pkg::OP_CHANGE
                                       && $signed(pri_reg) == gone_reg)) begin
                    state_next = imh_pkg::S_ROOT;
                end else begin
                    state_next = imh_pkg::S_UPCMP;
                end
            end
            imh_pkg::S_UPCMP: begin
                // parent >= node: move parent down, continue upward.
                cmp_a = rd_pri; cmp_b = node_pri;
                if (cmp_ge) begin
                    h_we = 1'b1; h_wa = idx_reg; h_wd = h_rd;
                    p_we = 1'b1; p_wa = h_rd[KW-1:0]; p_wd = {1'b1, idx_reg};
                    idx_next = oth_reg;
                    state_next = imh_pkg::S_UPRD;
                end else begin
                    state_next = imh_pkg::S_ROOT;
                end
            end
            imh_pkg::S_DNRD: begin
                // Place node at idx; read left child.
                h_we = 1'b1; h_wa = idx_reg; h_wd = node_reg;
                p_we = 1'b1; p_wa = node_reg[KW-1:0]; p_wd = {1'b1, idx_reg};
                h_ra = lchild[SW-1:0];
                if (lchild >= (CW+1)'(cnt_reg)) begin
                    state_next = imh_pkg::S_ROOT;
                end else begin
                    state_next = imh_pkg::S_DNCMP;
                end
            end
            imh_pkg::S_DNCMP: begin
                // Left child in; read the right child slot, used only when it exists.
                lc_next  = h_rd;
                oth_next = lchild[SW-1:0];
                h_ra = SW'(lchild + 1'b1);
                state_next = imh_pkg::S_DNCMP2;
            end
            imh_pkg::S_DNCMP2: begin
                // Pick child (right only if left > right), then compare node.
                logic [EW-1:0] ch;
                logic [SW-1:0] ci;
                ch = lc_reg; ci = oth_reg;
                cmp_a = rd_pri; cmp_b = lc_pri;
                if ((lchild + 1'b1) < (CW+1)'(cnt_reg) && !cmp_ge) begin
                    ch = h_rd; ci = SW'(lchild + 1'b1);
                end
                if ($signed(node_pri) >= $signed(ch[EW-1:KW])) begin
                    h_we = 1'b1; h_wa = idx_reg; h_wd = ch;
                    p_we = 1'b1; p_wa = ch[KW-1:0]; p_wd = {1'b1, idx_reg};
                    idx_next = ci;
                    state_next = imh_pkg::S_DNRD;
                end else begin
                    state_next = imh_pkg::S_ROOT;
                end
            end
            imh_pkg::S_ROOT: begin
                h_ra = '0;
                p_ra = key_reg;
                // Hold while the previous result item still waits.
                if (!ov_reg || m_tready) begin
                    state_next = imh_pkg::S_QRY;
                end
            end
            imh_pkg::S_QRY: begin
                // Root in h_rd; fetch queried slot.
                out_next = '0;
                if (cnt_reg != '0) begin
                    out_next[7:0]  = h_rd[KW-1:0];
                    out_next[39:8] = h_rd[EW-1:KW];
                end
                out_next[40]    = (cnt_reg == '0);
                out_next[41]    = p_rd[SW];
                out_next[80:74] = cnt_reg;
                out_next[83:81] = st_reg;
                h_ra = p_rd[SW-1:0];
                state_next = imh_pkg::S_OUT;
            end
            imh_pkg::S_OUT: begin
                if (out_reg[41]) begin
                    out_next[73:42] = h_rd[EW-1:KW];
                end
                ov_next = 1'b1;
                state_next = imh_pkg::S_IDLE;
            end
            default: state_next = imh_pkg::S_IDLE;
        endcase
    end

    `IMH_ASSERT_NEXT(a_accept, aclk, aresetn, s_acc, state_reg == imh_pkg::S_LOOK, "no lookup")
    `IMH_ASSERT_IMPL(a_count_cap, aclk, aresetn, 1'b1, cnt_reg <= CapCnt, "count over capacity")
    `IMH_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_wait, m_tvalid && $stable(m_tdata), "dropped")
endmodule
`default_nettype wire

>>> hdl/imh_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module imh_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire
